// ----- hw/rtl/nnds_pkg.sv -----
// Shared types and constants for the nearest-neighbor YUV 4:2:0 downscaler.
`timescale 1ns / 1ps

package nnds_pkg;

    localparam int CFG_W   = 13;
    localparam int PIXEL_W = 8;
    localparam int APB_W   = 32;
    localparam int ADDR_W  = 4;

    // Smallest size any plane dimension is clamped to before halving.
    localparam int MIN_DIM = 2;

    localparam int RST_SRC_WIDTH  = 640;
    localparam int RST_SRC_HEIGHT = 480;
    localparam int RST_DST_WIDTH  = 224;
    localparam int RST_DST_HEIGHT = 224;

    typedef enum logic [1:0] {
        PLANE_Y = 2'd0,
        PLANE_U = 2'd1,
        PLANE_V = 2'd2
    } plane_t;

    typedef enum logic [1:0] {
        REG_SRC_WIDTH  = 2'd0,
        REG_SRC_HEIGHT = 2'd1,
        REG_DST_WIDTH  = 2'd2,
        REG_DST_HEIGHT = 2'd3
    } reg_index_t;

endpackage

// ----- hw/rtl/nearest_neighbor_yuv420_downscaler.sv -----
// Top level of the nearest-neighbor YUV 4:2:0 downscaler with its APB register file.
// A selected byte passes through the input register and the result register before it is offered on the output.
// Throughput: one input byte per cycle while the output is not stalled; the accumulator add-and-compare
// between the input register and the result register is the only per-byte work.
// Bytes that are not selected produce no output transaction.
// Reset (rst_n low, asynchronous) loads 640x480 -> 224x224 and restarts at the Y plane.
`timescale 1ns / 1ps

module nearest_neighbor_yuv420_downscaler #(
    parameter int MAX_DIM = 4096
) (
    input  logic                         clk,
    input  logic                         rst_n,
    // APB configuration port
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [nnds_pkg::ADDR_W-1:0]  paddr,
    input  logic [nnds_pkg::APB_W-1:0]   pwdata,
    output logic [nnds_pkg::APB_W-1:0]   prdata,
    output logic                         pready,
    // Source byte stream
    input  logic                         s_axis_tvalid,
    output logic                         s_axis_tready,
    input  logic [nnds_pkg::PIXEL_W-1:0] s_axis_tdata,   // [7:0] pixel_in
    // Destination byte stream
    output logic                         m_axis_tvalid,
    input  logic                         m_axis_tready,
    output logic [nnds_pkg::PIXEL_W-1:0] m_axis_tdata,   // [7:0] pixel_out
    output logic [1:0]                   m_axis_tuser,   // [1:0] plane_id
    output logic                         m_axis_tlast    // frame_end
);

    localparam int CFG_W = nnds_pkg::CFG_W;
    localparam int DIM_W = $clog2(MAX_DIM + 1);
    localparam int SRC_W = $clog2(MAX_DIM);
    localparam int ACC_W = $clog2(MAX_DIM * MAX_DIM + 1);
    localparam int CMP_W = (DIM_W > CFG_W) ? DIM_W : CFG_W;

    localparam int RST_SW = (nnds_pkg::RST_SRC_WIDTH > MAX_DIM) ? MAX_DIM
                                                                : nnds_pkg::RST_SRC_WIDTH;
    localparam int RST_SH = (nnds_pkg::RST_SRC_HEIGHT > MAX_DIM) ? MAX_DIM
                                                                 : nnds_pkg::RST_SRC_HEIGHT;
    localparam int RST_DW = (nnds_pkg::RST_DST_WIDTH > RST_SW) ? RST_SW
                                                               : nnds_pkg::RST_DST_WIDTH;
    localparam int RST_DH = (nnds_pkg::RST_DST_HEIGHT > RST_SH) ? RST_SH
                                                                : nnds_pkg::RST_DST_HEIGHT;

    typedef struct packed {
        logic [DIM_W-1:0] sw;
        logic [DIM_W-1:0] sh;
        logic [DIM_W-1:0] dw;
        logic [DIM_W-1:0] dh;
    } dims_t;

    function automatic logic [DIM_W-1:0] clamp_dim(input logic [CFG_W-1:0] v,
                                                   input logic [DIM_W-1:0] hi);
        logic [CMP_W-1:0] ve;
        logic [CMP_W-1:0] he;
        ve = CMP_W'(v);
        he = CMP_W'(hi);
        if (ve < CMP_W'(nnds_pkg::MIN_DIM))
            clamp_dim = DIM_W'(nnds_pkg::MIN_DIM);
        else if (ve > he)
            clamp_dim = hi;
        else
            clamp_dim = ve[DIM_W-1:0];
    endfunction

    // Chroma planes use the truncated halves of the clamped luma sizes.
    function automatic dims_t dims_of(input nnds_pkg::plane_t p, input dims_t d);
        dims_t r;
        r = d;
        if (p != nnds_pkg::PLANE_Y)
        begin
            r.sw = d.sw >> 1;
            r.sh = d.sh >> 1;
            r.dw = d.dw >> 1;
            r.dh = d.dh >> 1;
        end
        return r;
    endfunction

    // Configuration registers
    logic [CFG_W-1:0] src_width_reg, src_width_next;
    logic [CFG_W-1:0] src_height_reg, src_height_next;
    logic [CFG_W-1:0] dst_width_reg, dst_width_next;
    logic [CFG_W-1:0] dst_height_reg, dst_height_next;
    dims_t            dims_reg, dims_next;
    logic             cfg_wr;
    nnds_pkg::reg_index_t cfg_idx;

    // Scan state
    nnds_pkg::plane_t plane_reg, plane_next;
    logic [SRC_W-1:0] src_col_reg, src_col_next;
    logic [SRC_W-1:0] src_row_reg, src_row_next;
    logic [DIM_W-1:0] dst_col_reg, dst_col_next;
    logic [DIM_W-1:0] dst_row_reg, dst_row_next;
    logic [ACC_W-1:0] col_target_reg, col_target_next;
    logic [ACC_W-1:0] col_limit_reg, col_limit_next;
    logic [ACC_W-1:0] row_target_reg, row_target_next;
    logic [ACC_W-1:0] row_limit_reg, row_limit_next;
    logic             row_sel_reg, row_sel_next;

    // Input and result registers
    logic                         in_valid_reg;
    logic [nnds_pkg::PIXEL_W-1:0] in_pixel_reg;
    logic                         out_valid_reg;
    logic [nnds_pkg::PIXEL_W-1:0] out_pixel_reg;
    nnds_pkg::plane_t             out_plane_reg;
    logic                         out_last_reg;

    logic             advance;
    logic             proc;
    dims_t            cur;
    dims_t            nd;
    nnds_pkg::plane_t plane_after;
    logic             col_sel;
    logic             emit;
    logic             frame_end;
    logic [DIM_W-1:0] src_col_inc;
    logic [DIM_W-1:0] src_row_inc;
    logic             line_end;
    logic [DIM_W-1:0] row_dst;
    logic [ACC_W-1:0] row_tgt;
    logic [ACC_W-1:0] row_lim;

    // ---------------- APB register file ----------------
    assign pready  = 1'b1;
    assign cfg_idx = nnds_pkg::reg_index_t'(paddr[3:2]);
    assign cfg_wr  = psel && penable && pwrite && pready;

    always_comb
    begin
        src_width_next  = src_width_reg;
        src_height_next = src_height_reg;
        dst_width_next  = dst_width_reg;
        dst_height_next = dst_height_reg;
        if (cfg_wr)
        begin
            unique case (cfg_idx)
                nnds_pkg::REG_SRC_WIDTH:  src_width_next  = pwdata[CFG_W-1:0];
                nnds_pkg::REG_SRC_HEIGHT: src_height_next = pwdata[CFG_W-1:0];
                nnds_pkg::REG_DST_WIDTH:  dst_width_next  = pwdata[CFG_W-1:0];
                nnds_pkg::REG_DST_HEIGHT: dst_height_next = pwdata[CFG_W-1:0];
                default: ;
            endcase
        end
        dims_next.sw = clamp_dim(src_width_next, DIM_W'(MAX_DIM));
        dims_next.sh = clamp_dim(src_height_next, DIM_W'(MAX_DIM));
        dims_next.dw = clamp_dim(dst_width_next, dims_next.sw);
        dims_next.dh = clamp_dim(dst_height_next, dims_next.sh);
    end

    always_comb
    begin
        unique case (cfg_idx)
            nnds_pkg::REG_SRC_WIDTH:  prdata = nnds_pkg::APB_W'(src_width_reg);
            nnds_pkg::REG_SRC_HEIGHT: prdata = nnds_pkg::APB_W'(src_height_reg);
            nnds_pkg::REG_DST_WIDTH:  prdata = nnds_pkg::APB_W'(dst_width_reg);
            nnds_pkg::REG_DST_HEIGHT: prdata = nnds_pkg::APB_W'(dst_height_reg);
            default:                  prdata = '0;
        endcase
    end

    // ---------------- Stream handshake ----------------
    assign advance       = !out_valid_reg || m_axis_tready;
    assign s_axis_tready = !in_valid_reg || advance;
    assign proc          = in_valid_reg && advance;

    // ---------------- Selection logic ----------------
    always_comb
    begin
        unique case (plane_reg)
            nnds_pkg::PLANE_Y: plane_after = nnds_pkg::PLANE_U;
            nnds_pkg::PLANE_U: plane_after = nnds_pkg::PLANE_V;
            nnds_pkg::PLANE_V: plane_after = nnds_pkg::PLANE_Y;
            default:           plane_after = nnds_pkg::PLANE_Y;
        endcase
    end

    always_comb
    begin
        cur       = dims_of(plane_reg, dims_reg);
        nd        = dims_of(plane_after, dims_reg);
        col_sel   = (dst_col_reg < cur.dw) && (col_target_reg < col_limit_reg);
        emit      = row_sel_reg && col_sel;
        frame_end = (plane_reg == nnds_pkg::PLANE_V) && (dst_row_reg == cur.dh - 1'b1)
                    && (dst_col_reg == cur.dw - 1'b1);

        src_col_inc = DIM_W'(src_col_reg) + 1'b1;
        src_row_inc = DIM_W'(src_row_reg) + 1'b1;
        line_end    = src_col_inc >= cur.sw;
        row_dst     = dst_row_reg + DIM_W'(row_sel_reg);
        row_tgt     = row_sel_reg ? row_target_reg + ACC_W'(cur.sh) : row_target_reg;
        row_lim     = row_limit_reg + ACC_W'(cur.dh);

        plane_next      = plane_reg;
        src_col_next    = src_col_reg;
        src_row_next    = src_row_reg;
        dst_col_next    = dst_col_reg;
        dst_row_next    = dst_row_reg;
        col_target_next = col_target_reg;
        col_limit_next  = col_limit_reg;
        row_target_next = row_target_reg;
        row_limit_next  = row_limit_reg;
        row_sel_next    = row_sel_reg;

        if (cfg_wr)
        begin
            // Any register write restarts the frame with the new sizes.
            plane_next      = nnds_pkg::PLANE_Y;
            src_col_next    = '0;
            src_row_next    = '0;
            dst_col_next    = '0;
            dst_row_next    = '0;
            col_target_next = '0;
            col_limit_next  = ACC_W'(dims_next.dw);
            row_target_next = '0;
            row_limit_next  = ACC_W'(dims_next.dh);
            row_sel_next    = 1'b1;
        end
        else if (proc)
        begin
            dst_col_next    = dst_col_reg + DIM_W'(col_sel);
            col_target_next = col_sel ? col_target_reg + ACC_W'(cur.sw) : col_target_reg;
            src_col_next    = src_col_inc[SRC_W-1:0];
            col_limit_next  = col_limit_reg + ACC_W'(cur.dw);
            if (line_end)
            begin
                src_col_next    = '0;
                dst_col_next    = '0;
                col_target_next = '0;
                col_limit_next  = ACC_W'(cur.dw);
                dst_row_next    = row_dst;
                row_target_next = row_tgt;
                src_row_next    = src_row_inc[SRC_W-1:0];
                row_limit_next  = row_lim;
                row_sel_next    = (row_dst < cur.dh) && (row_tgt < row_lim);
                if (src_row_inc >= cur.sh)
                begin
                    plane_next      = plane_after;
                    src_col_next    = '0;
                    src_row_next    = '0;
                    dst_col_next    = '0;
                    dst_row_next    = '0;
                    col_target_next = '0;
                    col_limit_next  = ACC_W'(nd.dw);
                    row_target_next = '0;
                    row_limit_next  = ACC_W'(nd.dh);
                    row_sel_next    = 1'b1;
                end
            end
        end
    end

    // ---------------- Registers ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            src_width_reg   <= CFG_W'(nnds_pkg::RST_SRC_WIDTH);
            src_height_reg  <= CFG_W'(nnds_pkg::RST_SRC_HEIGHT);
            dst_width_reg   <= CFG_W'(nnds_pkg::RST_DST_WIDTH);
            dst_height_reg  <= CFG_W'(nnds_pkg::RST_DST_HEIGHT);
            dims_reg.sw     <= DIM_W'(RST_SW);
            dims_reg.sh     <= DIM_W'(RST_SH);
            dims_reg.dw     <= DIM_W'(RST_DW);
            dims_reg.dh     <= DIM_W'(RST_DH);
            plane_reg       <= nnds_pkg::PLANE_Y;
            src_col_reg     <= '0;
            src_row_reg     <= '0;
            dst_col_reg     <= '0;
            dst_row_reg     <= '0;
            col_target_reg  <= '0;
            col_limit_reg   <= ACC_W'(RST_DW);
            row_target_reg  <= '0;
            row_limit_reg   <= ACC_W'(RST_DH);
            row_sel_reg     <= 1'b1;
            in_valid_reg    <= 1'b0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            src_width_reg   <= src_width_next;
            src_height_reg  <= src_height_next;
            dst_width_reg   <= dst_width_next;
            dst_height_reg  <= dst_height_next;
            dims_reg        <= dims_next;
            plane_reg       <= plane_next;
            src_col_reg     <= src_col_next;
            src_row_reg     <= src_row_next;
            dst_col_reg     <= dst_col_next;
            dst_row_reg     <= dst_row_next;
            col_target_reg  <= col_target_next;
            col_limit_reg   <= col_limit_next;
            row_target_reg  <= row_target_next;
            row_limit_reg   <= row_limit_next;
            row_sel_reg     <= row_sel_next;
            if (s_axis_tready)
                in_valid_reg <= s_axis_tvalid;
            if (advance)
                out_valid_reg <= proc && emit;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tvalid && s_axis_tready)
            in_pixel_reg <= s_axis_tdata;
        if (proc && emit)
        begin
            out_pixel_reg <= in_pixel_reg;
            out_plane_reg <= plane_reg;
            out_last_reg  <= frame_end;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_pixel_reg;
    assign m_axis_tuser  = out_plane_reg;
    assign m_axis_tlast  = out_last_reg;

    // ---------------- Assertions ----------------
    a_last_only_in_v: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tlast |-> m_axis_tuser == nnds_pkg::PLANE_V)
        else $error("end of frame flagged outside the V plane");

    a_dst_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        dst_col_reg <= cur.dw && dst_row_reg <= cur.dh)
        else $error("destination counters ran past the plane size");

    a_src_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        DIM_W'(src_col_reg) < cur.sw && DIM_W'(src_row_reg) < cur.sh)
        else $error("source position outside the plane");

    a_stall_keeps_input: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid_reg && !advance |=> in_valid_reg && $stable(in_pixel_reg))
        else $error("buffered source byte lost during output stall");

endmodule

// ----- tb/sv/tb_nearest_neighbor_yuv420_downscaler.sv -----
// Testbench for the nearest-neighbor YUV 4:2:0 downscaler with its own predictor.
`timescale 1ns / 1ps

module tb_nearest_neighbor_yuv420_downscaler;

    localparam int MAX_DIM      = 4096;
    localparam int DRAIN_CYCLES = 8;
    localparam int MAX_REPORTS  = 50;

    typedef struct packed {
        logic [nnds_pkg::PIXEL_W-1:0] pixel;
        nnds_pkg::plane_t             plane_id;
        logic                         frame_end;
    } scaled_byte_t;

    typedef struct {
        logic [12:0] sw;
        logic [12:0] sh;
        logic [12:0] dw;
        logic [12:0] dh;
    } plane_size_t;

    logic                         clk = 1'b0;
    logic                         rst_n = 1'b0;
    logic                         psel = 1'b0;
    logic                         penable = 1'b0;
    logic                         pwrite = 1'b0;
    logic [nnds_pkg::ADDR_W-1:0]  paddr = '0;
    logic [nnds_pkg::APB_W-1:0]   pwdata = '0;
    logic [nnds_pkg::APB_W-1:0]   prdata;
    logic                         pready;
    logic                         s_axis_tvalid = 1'b0;
    logic                         s_axis_tready;
    logic [nnds_pkg::PIXEL_W-1:0] s_axis_tdata = '0;   // [7:0] pixel_in
    logic                         m_axis_tvalid;
    logic                         m_axis_tready = 1'b0;
    logic [nnds_pkg::PIXEL_W-1:0] m_axis_tdata;        // [7:0] pixel_out
    logic [1:0]                   m_axis_tuser;        // [1:0] plane_id
    logic                         m_axis_tlast;        // frame_end

    int tx_idle_pct = 29;
    int rx_idle_pct = 47;
    int rx_hold = 0;
    int error_count = 0;

    // Predicted view of the block: register copies, sampling state and pending output bytes.
    logic [12:0]      size_reg [4];
    nnds_pkg::plane_t cur_plane;
    logic [12:0]      src_col, src_row, dst_col, dst_row;
    logic [24:0]      col_target, col_limit, row_target, row_limit;
    bit               row_sel;
    scaled_byte_t     pending_bytes [$];

    nearest_neighbor_yuv420_downscaler #(
        .MAX_DIM(MAX_DIM)
    ) DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata),
        .m_axis_tuser (m_axis_tuser),
        .m_axis_tlast (m_axis_tlast)
    );

    always #2 clk = ~clk;

    function automatic plane_size_t plane_size(nnds_pkg::plane_t p);
        plane_size_t r;
        int a, b, c, d;
        a = size_reg[nnds_pkg::REG_SRC_WIDTH];
        b = size_reg[nnds_pkg::REG_SRC_HEIGHT];
        a = (a < nnds_pkg::MIN_DIM) ? nnds_pkg::MIN_DIM : (a > MAX_DIM) ? MAX_DIM : a;
        b = (b < nnds_pkg::MIN_DIM) ? nnds_pkg::MIN_DIM : (b > MAX_DIM) ? MAX_DIM : b;
        c = size_reg[nnds_pkg::REG_DST_WIDTH];
        d = size_reg[nnds_pkg::REG_DST_HEIGHT];
        c = (c < nnds_pkg::MIN_DIM) ? nnds_pkg::MIN_DIM : (c > a) ? a : c;
        d = (d < nnds_pkg::MIN_DIM) ? nnds_pkg::MIN_DIM : (d > b) ? b : d;
        if (p != nnds_pkg::PLANE_Y)
        begin
            a = a / 2;
            b = b / 2;
            c = c / 2;
            d = d / 2;
        end
        r.sw = 13'(a);
        r.sh = 13'(b);
        r.dw = 13'(c);
        r.dh = 13'(d);
        return r;
    endfunction

    function automatic void begin_plane(nnds_pkg::plane_t p);
        plane_size_t d;
        d = plane_size(p);
        cur_plane  = p;
        src_col    = '0;
        src_row    = '0;
        dst_col    = '0;
        dst_row    = '0;
        col_target = '0;
        col_limit  = 25'(d.dw);
        row_target = '0;
        row_limit  = 25'(d.dh);
        row_sel    = 1'b1;
    endfunction

    function automatic int frame_bytes();
        plane_size_t y, c;
        y = plane_size(nnds_pkg::PLANE_Y);
        c = plane_size(nnds_pkg::PLANE_U);
        return int'(y.sw) * int'(y.sh) + 2 * int'(c.sw) * int'(c.sh);
    endfunction

    // A source byte is passed on when both its column and its row are selected.
    function automatic void predict_scaled_byte(logic [nnds_pkg::PIXEL_W-1:0] px);
        plane_size_t  d;
        bit           col_sel;
        scaled_byte_t e;
        d = plane_size(cur_plane);
        col_sel = (dst_col < d.dw) && (col_target < col_limit);
        if (row_sel && col_sel)
        begin
            e.pixel     = px;
            e.plane_id  = cur_plane;
            e.frame_end = (cur_plane == nnds_pkg::PLANE_V) && (dst_row + 13'd1 == d.dh)
                          && (dst_col + 13'd1 == d.dw);
            pending_bytes.push_back(e);
        end
        if (col_sel)
        begin
            dst_col    = dst_col + 13'd1;
            col_target = col_target + 25'(d.sw);
        end
        src_col   = src_col + 13'd1;
        col_limit = col_limit + 25'(d.dw);
        if (src_col >= d.sw)
        begin
            src_col    = '0;
            dst_col    = '0;
            col_target = '0;
            col_limit  = 25'(d.dw);
            if (row_sel)
            begin
                dst_row    = dst_row + 13'd1;
                row_target = row_target + 25'(d.sh);
            end
            src_row   = src_row + 13'd1;
            row_limit = row_limit + 25'(d.dh);
            row_sel   = (dst_row < d.dh) && (row_target < row_limit);
            if (src_row >= d.sh)
            begin
                case (cur_plane)
                    nnds_pkg::PLANE_Y: begin_plane(nnds_pkg::PLANE_U);
                    nnds_pkg::PLANE_U: begin_plane(nnds_pkg::PLANE_V);
                    default:           begin_plane(nnds_pkg::PLANE_Y);
                endcase
            end
        end
    endfunction

    task automatic report_mismatch(string msg);
        if (error_count < MAX_REPORTS)
            $display("MISMATCH at %0t ns: %s", $time, msg);
        error_count++;
    endtask

    // Receiver: random stalls, or a counted hold-off when a test requests one.
    always @(posedge clk)
    begin
        if (rx_hold > 0)
        begin
            m_axis_tready <= 1'b0;
            rx_hold <= rx_hold - 1;
        end
        else
        begin
            m_axis_tready <= ($urandom_range(99) >= rx_idle_pct);
        end
    end

    always @(posedge clk)
    begin : check_output
        scaled_byte_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (pending_bytes.size() == 0)
            begin
                report_mismatch($sformatf("unexpected output byte %0h plane %0d",
                                          m_axis_tdata, m_axis_tuser));
            end
            else
            begin
                want = pending_bytes.pop_front();
                if (m_axis_tdata !== want.pixel)
                    report_mismatch($sformatf("pixel_out %0h, expected %0h",
                                              m_axis_tdata, want.pixel));
                if (m_axis_tuser !== want.plane_id)
                    report_mismatch($sformatf("plane_id %0d, expected %0d",
                                              m_axis_tuser, want.plane_id));
                if (m_axis_tlast !== want.frame_end)
                    report_mismatch($sformatf("frame_end %0b, expected %0b",
                                              m_axis_tlast, want.frame_end));
            end
        end
    end

    task automatic send_pixel(logic [nnds_pkg::PIXEL_W-1:0] px);
        while ($urandom_range(99) < tx_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= px;
        do
            @(posedge clk);
        while (!s_axis_tready);
        predict_scaled_byte(px);
    endtask

    task automatic send_random_bytes(int count);
        for (int k = 0; k < count; k++)
            send_pixel(nnds_pkg::PIXEL_W'($urandom_range(255)));
    endtask

    // Unselected bytes may still be in flight once the last result is out.
    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        while (pending_bytes.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_size(nnds_pkg::reg_index_t idx, logic [12:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= nnds_pkg::APB_W'(value);
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        size_reg[idx] = value;
        begin_plane(nnds_pkg::PLANE_Y);
        @(posedge clk);
    endtask

    task automatic write_sizes(int sw, int sh, int dw, int dh);
        write_size(nnds_pkg::REG_SRC_WIDTH, 13'(sw));
        write_size(nnds_pkg::REG_SRC_HEIGHT, 13'(sh));
        write_size(nnds_pkg::REG_DST_WIDTH, 13'(dw));
        write_size(nnds_pkg::REG_DST_HEIGHT, 13'(dh));
    endtask

    function automatic int random_dst(int src);
        case ($urandom_range(3))
            0, 1:    return $urandom_range(2, src);
            2:       return $urandom_range(0, 1);
            default: return $urandom_range(0, 8191);
        endcase
    endfunction

    // Start of the first line at the sizes loaded by reset.
    task automatic test_reset_sizes();
        for (int k = 0; k < 4; k++)
            send_pixel(k[0] ? 8'hFF : 8'h00);
        wait_drained();
    endtask

    // One whole tiny frame with a destination width below the minimum.
    task automatic test_small_frame();
        write_sizes(4, 2, 0, 1);
        for (int k = 0; k < 12; k++)
            send_pixel(8'(255 - k * 17));
        wait_drained();
    endtask

    // Source width below the minimum and destination sizes above the source.
    task automatic test_clamped_sizes();
        write_sizes(0, 3, 8191, 8191);
        for (int k = 0; k < 9; k++)
            send_pixel(8'(k * 29));
        wait_drained();
    endtask

    // A few settings at the largest sizes, sent only in part.
    task automatic test_large_sizes();
        write_sizes(8191, 4096, 8191, 2);
        send_random_bytes(150);
        wait_drained();
        write_sizes(5000, 3, 4095, 8191);
        send_random_bytes(150);
        wait_drained();
        write_sizes(2, 8191, 8191, 4096);
        send_random_bytes(60);
        wait_drained();
    endtask

    // Receiver holds off while a frame with every byte selected keeps coming.
    task automatic test_backpressure();
        write_sizes(8, 8, 8, 8);
        rx_hold <= 300;
        send_random_bytes(2 * frame_bytes());
        wait_drained();
        send_random_bytes(frame_bytes());
        wait_drained();
    endtask

    // Random small sizes: mostly whole frames, sometimes a frame cut short.
    task automatic test_random_frames(int n_items);
        int sent;
        int sw, sh, len, part;
        sent = 0;
        while (sent < n_items)
        begin
            sw = ($urandom_range(7) == 0) ? $urandom_range(0, 1) : $urandom_range(2, 14);
            sh = ($urandom_range(7) == 0) ? $urandom_range(0, 1) : $urandom_range(2, 12);
            write_sizes(sw, sh, random_dst(sw), random_dst(sh));
            len = frame_bytes();
            repeat ($urandom_range(1, 3))
            begin
                send_random_bytes(len);
                sent += len;
            end
            if ($urandom_range(3) == 0)
            begin
                part = $urandom_range(1, len - 1);
                send_random_bytes(part);
                sent += part;
            end
            wait_drained();
        end
    endtask

    initial
    begin
        size_reg[nnds_pkg::REG_SRC_WIDTH]  = 13'(nnds_pkg::RST_SRC_WIDTH);
        size_reg[nnds_pkg::REG_SRC_HEIGHT] = 13'(nnds_pkg::RST_SRC_HEIGHT);
        size_reg[nnds_pkg::REG_DST_WIDTH]  = 13'(nnds_pkg::RST_DST_WIDTH);
        size_reg[nnds_pkg::REG_DST_HEIGHT] = 13'(nnds_pkg::RST_DST_HEIGHT);
        begin_plane(nnds_pkg::PLANE_Y);
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_sizes();
        test_small_frame();
        test_clamped_sizes();
        test_random_frames(150);

        tx_idle_pct = 47;
        rx_idle_pct = 29;
        test_large_sizes();
        test_random_frames(150);

        tx_idle_pct = 0;
        rx_idle_pct = 0;
        test_backpressure();
        test_random_frames(150);

        wait_drained();
        if (error_count == 0 && pending_bytes.size() == 0)
            $display("nearest_neighbor_yuv420_downscaler test passed");
        else
            $display("nearest_neighbor_yuv420_downscaler test failed");
        $finish;
    end

    initial
    begin
        #2_000_000;
        $display("nearest_neighbor_yuv420_downscaler test failed");
        $finish;
    end

endmodule
